@@ rtl/periodic_disc_overlap_push_unit_macros.svh @@
// assertion helpers for the checker file
`ifndef PERIODIC_DISC_OVERLAP_PUSH_UNIT_MACROS_SVH
`define PERIODIC_DISC_OVERLAP_PUSH_UNIT_MACROS_SVH

// property checked on every rising edge outside reset
`define PDOP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the following cycle
`define PDOP_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

@@ rtl/pdop_pkg.sv @@
// ----------------------------------------------------------------------------
// pdop_pkg
// types, widths and register codes of the periodic disc overlap push unit
// ----------------------------------------------------------------------------
package pdop_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int DIAM_WIDTH  = 29;
    localparam int BOX_WIDTH   = 31;
    localparam int CFG_WIDTH   = 31;
    localparam int CFG_IDX_W   = 2;
    localparam int EXT_WIDTH   = COORD_WIDTH + 2;
    localparam int SQ_WIDTH    = 2 * DIAM_WIDTH;
    localparam int ROOT_STEPS  = DIAM_WIDTH;
    localparam int QUO_WIDTH   = DIAM_WIDTH;

    localparam logic [DIAM_WIDTH-1:0] DIAM_RESET  = DIAM_WIDTH'(10485760);
    localparam logic [BOX_WIDTH-1:0]  BOX_W_RESET = BOX_WIDTH'(2011797914);
    localparam logic [BOX_WIDTH-1:0]  BOX_H_RESET = BOX_WIDTH'(1270604313);
    localparam logic [SQ_WIDTH-1:0]   DD_RESET    =
        SQ_WIDTH'(DIAM_RESET) * SQ_WIDTH'(DIAM_RESET);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIAM  = 2'd0,
        CFG_BOX_W = 2'd1,
        CFG_BOX_H = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] center_x;
        logic signed [COORD_WIDTH-1:0] center_y;
        logic signed [COORD_WIDTH-1:0] other_x;
        logic signed [COORD_WIDTH-1:0] other_y;
    } pdop_in_t;

    typedef struct packed {
        logic                          overlap;
        logic                          coincident;
        logic signed [COORD_WIDTH-1:0] push_x;
        logic signed [COORD_WIDTH-1:0] push_y;
    } pdop_out_t;

endpackage

@@ rtl/pdop_isqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// pdop_isqrt_pipe
// integer square root, one result bit per register stage
// ----------------------------------------------------------------------------
module pdop_isqrt_pipe
    import pdop_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [SQ_WIDTH-1:0]   in_sq,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [DIAM_WIDTH-1:0] out_root,
    output logic [SIDE_W-1:0]     out_side
);

    logic [SQ_WIDTH-1:0] rem_reg  [ROOT_STEPS];
    logic [SQ_WIDTH-1:0] res_reg  [ROOT_STEPS];
    logic [SIDE_W-1:0]   side_reg [ROOT_STEPS];
    logic [ROOT_STEPS-1:0] valid_reg;

    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_step
        localparam logic [SQ_WIDTH:0] BIT = (SQ_WIDTH+1)'(1) << (2 * (ROOT_STEPS - 1 - k));
        logic [SQ_WIDTH-1:0] rem_in;
        logic [SQ_WIDTH-1:0] res_in;
        logic [SIDE_W-1:0]   side_in;
        logic                v_in;
        logic [SQ_WIDTH:0]   trial;
        logic                take;
        logic [SQ_WIDTH-1:0] rem_next;
        logic [SQ_WIDTH-1:0] res_next;

        if (k == 0)
        begin : g_first
            assign rem_in  = in_sq;
            assign res_in  = '0;
            assign side_in = in_side;
            assign v_in    = in_valid;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign res_in  = res_reg[k-1];
            assign side_in = side_reg[k-1];
            assign v_in    = valid_reg[k-1];
        end

        assign trial    = {1'b0, res_in} + BIT;
        assign take     = {1'b0, rem_in} >= trial;
        assign rem_next = take ? rem_in - trial[SQ_WIDTH-1:0] : rem_in;
        assign res_next = take ? (res_in >> 1) + BIT[SQ_WIDTH-1:0] : res_in >> 1;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                res_reg[k]  <= res_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_STEPS-1];
    assign out_root  = res_reg[ROOT_STEPS-1][DIAM_WIDTH-1:0];
    assign out_side  = side_reg[ROOT_STEPS-1];

endmodule

@@ rtl/pdop_div_pipe.sv @@
// ----------------------------------------------------------------------------
// pdop_div_pipe
// two-lane restoring divider sharing one divisor, one quotient bit per stage
// ----------------------------------------------------------------------------
module pdop_div_pipe
    import pdop_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [SQ_WIDTH-1:0]   in_num_x,
    input  logic [SQ_WIDTH-1:0]   in_num_y,
    input  logic [DIAM_WIDTH:0]   in_dvs,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [QUO_WIDTH-1:0]  out_quo_x,
    output logic [QUO_WIDTH-1:0]  out_quo_y,
    output logic [SIDE_W-1:0]     out_side
);

    logic [SQ_WIDTH-1:0]  rx_reg   [QUO_WIDTH];
    logic [SQ_WIDTH-1:0]  ry_reg   [QUO_WIDTH];
    logic [QUO_WIDTH-1:0] qx_reg   [QUO_WIDTH];
    logic [QUO_WIDTH-1:0] qy_reg   [QUO_WIDTH];
    logic [DIAM_WIDTH:0]  dvs_reg  [QUO_WIDTH];
    logic [SIDE_W-1:0]    side_reg [QUO_WIDTH];
    logic [QUO_WIDTH-1:0] valid_reg;

    for (genvar k = 0; k < QUO_WIDTH; k++)
    begin : g_step
        localparam int SH = QUO_WIDTH - 1 - k;
        logic [SQ_WIDTH-1:0]  rx_in;
        logic [SQ_WIDTH-1:0]  ry_in;
        logic [QUO_WIDTH-1:0] qx_in;
        logic [QUO_WIDTH-1:0] qy_in;
        logic [DIAM_WIDTH:0]  dvs_in;
        logic [SIDE_W-1:0]    side_in;
        logic                 v_in;
        logic [SQ_WIDTH:0]    shifted;
        logic                 gx;
        logic                 gy;
        logic [QUO_WIDTH-1:0] qx_next;
        logic [QUO_WIDTH-1:0] qy_next;

        if (k == 0)
        begin : g_first
            assign rx_in   = in_num_x;
            assign ry_in   = in_num_y;
            assign qx_in   = '0;
            assign qy_in   = '0;
            assign dvs_in  = in_dvs;
            assign side_in = in_side;
            assign v_in    = in_valid;
        end
        else
        begin : g_next
            assign rx_in   = rx_reg[k-1];
            assign ry_in   = ry_reg[k-1];
            assign qx_in   = qx_reg[k-1];
            assign qy_in   = qy_reg[k-1];
            assign dvs_in  = dvs_reg[k-1];
            assign side_in = side_reg[k-1];
            assign v_in    = valid_reg[k-1];
        end

        assign shifted = (SQ_WIDTH+1)'(dvs_in) << SH;
        assign gx      = {1'b0, rx_in} >= shifted;
        assign gy      = {1'b0, ry_in} >= shifted;

        always_comb
        begin
            qx_next     = qx_in;
            qy_next     = qy_in;
            qx_next[SH] = gx;
            qy_next[SH] = gy;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg[k]   <= gx ? rx_in - shifted[SQ_WIDTH-1:0] : rx_in;
                ry_reg[k]   <= gy ? ry_in - shifted[SQ_WIDTH-1:0] : ry_in;
                qx_reg[k]   <= qx_next;
                qy_reg[k]   <= qy_next;
                dvs_reg[k]  <= dvs_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[QUO_WIDTH-1];
    assign out_quo_x = qx_reg[QUO_WIDTH-1];
    assign out_quo_y = qy_reg[QUO_WIDTH-1];
    assign out_side  = side_reg[QUO_WIDTH-1];

endmodule

@@ rtl/periodic_disc_overlap_push_unit.sv @@
// Takes one disc pair per cycle while the output is not stalled and returns
// one result per pair, in order, through 5 front stages, 29 square root stages,
// 3 stages for gap and products, 29 divider stages and 1 output register.
// The depth is set by the bit-per-stage square root and divider pipelines.
// When the output is stalled the whole pipeline holds, so in_ready follows
// out_ready while the output register is full. Registers may be written
// only while the pipeline is empty.
// ----------------------------------------------------------------------------
// periodic_disc_overlap_push_unit
// periodic image shift, overlap test and push for one pair of discs
// ----------------------------------------------------------------------------
module periodic_disc_overlap_push_unit
    import pdop_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_WIDTH-1:0] cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pdop_in_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pdop_out_t            out_data
);

    typedef struct packed {
        logic                  ovl;
        logic                  coinc;
        logic                  sx;
        logic                  sy;
        logic [DIAM_WIDTH-1:0] ax;
        logic [DIAM_WIDTH-1:0] ay;
    } root_side_t;

    typedef struct packed {
        logic ovl;
        logic coinc;
        logic sx;
        logic sy;
    } div_side_t;

    logic [DIAM_WIDTH-1:0] diam_reg;
    logic [BOX_WIDTH-1:0]  box_w_reg;
    logic [BOX_WIDTH-1:0]  box_h_reg;
    logic [SQ_WIDTH-1:0]   dd_reg;
    logic                  adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diam_reg  <= DIAM_RESET;
            box_w_reg <= BOX_W_RESET;
            box_h_reg <= BOX_H_RESET;
            dd_reg    <= DD_RESET;
        end
        else
        begin
            dd_reg <= SQ_WIDTH'(diam_reg) * SQ_WIDTH'(diam_reg);
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_idx))
                    CFG_DIAM:  diam_reg  <= cfg_wdata[DIAM_WIDTH-1:0];
                    CFG_BOX_W: box_w_reg <= cfg_wdata[BOX_WIDTH-1:0];
                    CFG_BOX_H: box_h_reg <= cfg_wdata[BOX_WIDTH-1:0];
                    default:   ;
                endcase
            end
        end
    end

    logic signed [EXT_WIDTH-1:0] dext;
    logic signed [EXT_WIDTH-1:0] wext;
    logic signed [EXT_WIDTH-1:0] hext;

    assign dext = EXT_WIDTH'(diam_reg);
    assign wext = EXT_WIDTH'(box_w_reg);
    assign hext = EXT_WIDTH'(box_h_reg);

    function automatic logic signed [EXT_WIDTH-1:0] wrap_shift(
        input logic signed [EXT_WIDTH-1:0] c,
        input logic signed [EXT_WIDTH-1:0] o,
        input logic signed [EXT_WIDTH-1:0] d,
        input logic signed [EXT_WIDTH-1:0] box
    );
        logic signed [EXT_WIDTH-1:0] lim;
        lim = box - d;
        if (o < d && c > lim)
            return o + box;
        else if (o > lim && c < d)
            return o - box;
        else
            return o;
    endfunction

    // stage 1: periodic image shift
    logic                        v1_reg;
    logic signed [EXT_WIDTH-1:0] cx1_reg, cy1_reg, ox1_reg, oy1_reg;
    logic signed [EXT_WIDTH-1:0] cx_e, cy_e;

    assign cx_e = EXT_WIDTH'(in_data.center_x);
    assign cy_e = EXT_WIDTH'(in_data.center_y);

    // stage 2: deltas
    logic                        v2_reg;
    logic signed [EXT_WIDTH-1:0] dx2_reg, dy2_reg;

    // stage 3: magnitudes and range flags
    logic                        v3_reg;
    logic                        near3_reg, coinc3_reg, sx3_reg, sy3_reg;
    logic [DIAM_WIDTH-1:0]       ax3_reg, ay3_reg;
    logic signed [EXT_WIDTH-1:0] mx, my;

    assign mx = dx2_reg[EXT_WIDTH-1] ? -dx2_reg : dx2_reg;
    assign my = dy2_reg[EXT_WIDTH-1] ? -dy2_reg : dy2_reg;

    // stage 4: squares
    logic                  v4_reg;
    root_side_t            side4_reg;
    logic                  near4_reg;
    logic [SQ_WIDTH-1:0]   sqx4_reg, sqy4_reg;

    // stage 5: sum and overlap test
    logic                  v5_reg;
    root_side_t            side5_reg;
    logic [SQ_WIDTH-1:0]   sq5_reg;
    logic [SQ_WIDTH-1:0]   sq_sum;

    assign sq_sum = sqx4_reg + sqy4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx1_reg <= cx_e;
            cy1_reg <= cy_e;
            ox1_reg <= wrap_shift(cx_e, EXT_WIDTH'(in_data.other_x), dext, wext);
            oy1_reg <= wrap_shift(cy_e, EXT_WIDTH'(in_data.other_y), dext, hext);

            dx2_reg <= cx1_reg - ox1_reg;
            dy2_reg <= cy1_reg - oy1_reg;

            near3_reg  <= (dx2_reg < dext) && (dx2_reg > -dext)
                       && (dy2_reg < dext) && (dy2_reg > -dext);
            coinc3_reg <= (dx2_reg == '0) && (dy2_reg == '0);
            sx3_reg    <= dx2_reg[EXT_WIDTH-1];
            sy3_reg    <= dy2_reg[EXT_WIDTH-1];
            ax3_reg    <= mx[DIAM_WIDTH-1:0];
            ay3_reg    <= my[DIAM_WIDTH-1:0];

            near4_reg        <= near3_reg && !coinc3_reg;
            side4_reg.ovl    <= 1'b0;
            side4_reg.coinc  <= coinc3_reg;
            side4_reg.sx     <= sx3_reg;
            side4_reg.sy     <= sy3_reg;
            side4_reg.ax     <= ax3_reg;
            side4_reg.ay     <= ay3_reg;
            sqx4_reg         <= SQ_WIDTH'(ax3_reg) * SQ_WIDTH'(ax3_reg);
            sqy4_reg         <= SQ_WIDTH'(ay3_reg) * SQ_WIDTH'(ay3_reg);

            side5_reg.ovl   <= near4_reg && (sq_sum < dd_reg);
            side5_reg.coinc <= side4_reg.coinc;
            side5_reg.sx    <= side4_reg.sx;
            side5_reg.sy    <= side4_reg.sy;
            side5_reg.ax    <= side4_reg.ax;
            side5_reg.ay    <= side4_reg.ay;
            sq5_reg         <= sq_sum;
        end
    end

    logic                  vr;
    logic [DIAM_WIDTH-1:0] root;
    root_side_t            side_r;

    pdop_isqrt_pipe #(
        .SIDE_W ($bits(root_side_t))
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v5_reg),
        .in_sq     (sq5_reg),
        .in_side   (side5_reg),
        .out_valid (vr),
        .out_root  (root),
        .out_side  (side_r)
    );

    // stage 6: gap, stage 7: products, stage 8: rounding numerator
    logic                  v6_reg, v7_reg, v8_reg;
    root_side_t            side6_reg, side7_reg;
    div_side_t             side8_reg;
    logic [DIAM_WIDTH-1:0] gap6_reg, dist6_reg, dist7_reg;
    logic [SQ_WIDTH-1:0]   nx7_reg, ny7_reg, nx8_reg, ny8_reg;
    logic [DIAM_WIDTH:0]   dvs8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (adv)
        begin
            v6_reg <= vr;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side6_reg <= side_r;
            dist6_reg <= root;
            gap6_reg  <= diam_reg - root;

            side7_reg <= side6_reg;
            dist7_reg <= dist6_reg;
            nx7_reg   <= SQ_WIDTH'(side6_reg.ax) * SQ_WIDTH'(gap6_reg);
            ny7_reg   <= SQ_WIDTH'(side6_reg.ay) * SQ_WIDTH'(gap6_reg);

            // adding dist before dividing by 2*dist rounds ties away from zero
            side8_reg.ovl   <= side7_reg.ovl;
            side8_reg.coinc <= side7_reg.coinc;
            side8_reg.sx    <= side7_reg.sx;
            side8_reg.sy    <= side7_reg.sy;
            nx8_reg         <= nx7_reg + SQ_WIDTH'(dist7_reg);
            ny8_reg         <= ny7_reg + SQ_WIDTH'(dist7_reg);
            dvs8_reg        <= {dist7_reg, 1'b0};
        end
    end

    logic                 vq;
    logic [QUO_WIDTH-1:0] qx, qy;
    div_side_t            side_q;

    pdop_div_pipe #(
        .SIDE_W ($bits(div_side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v8_reg),
        .in_num_x  (nx8_reg),
        .in_num_y  (ny8_reg),
        .in_dvs    (dvs8_reg),
        .in_side   (side8_reg),
        .out_valid (vq),
        .out_quo_x (qx),
        .out_quo_y (qy),
        .out_side  (side_q)
    );

    // output register
    logic                          out_valid_reg;
    pdop_out_t                     out_data_reg;
    logic signed [COORD_WIDTH-1:0] px, py;

    assign px = side_q.sx ? -COORD_WIDTH'(qx) : COORD_WIDTH'(qx);
    assign py = side_q.sy ? -COORD_WIDTH'(qy) : COORD_WIDTH'(qy);

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vq;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg.overlap    <= side_q.ovl;
            out_data_reg.coincident <= side_q.coinc;
            out_data_reg.push_x     <= side_q.ovl ? px : '0;
            out_data_reg.push_y     <= side_q.ovl ? py : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/pdop_checker.sv @@
// ----------------------------------------------------------------------------
// pdop_checker
// port-level checks of the periodic disc overlap push unit
// ----------------------------------------------------------------------------
`include "periodic_disc_overlap_push_unit_macros.svh"

module pdop_checker
    import pdop_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input pdop_out_t out_data
);

    logic both_flags;
    logic push_zero;

    assign both_flags = out_data.overlap && out_data.coincident;
    assign push_zero  = (out_data.push_x == '0) && (out_data.push_y == '0);

    `PDOP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
    `PDOP_ASSERT(a_flags_excl, !(out_valid && both_flags), "overlap and coincident both set")
    `PDOP_ASSERT(a_coinc_zero, !(out_valid && out_data.coincident) || push_zero, "coincident push")
    `PDOP_ASSERT(a_stall_in, !(out_valid && !out_ready) || !in_ready, "input taken in stall")

endmodule

bind periodic_disc_overlap_push_unit pdop_checker u_pdop_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
